/* rtl/estc_pkg.sv */
// Shared widths, calendar constants and reciprocals for the epoch-to-calendar converter.
package estc_pkg;

    // Word field widths.
    localparam int unsigned UNIX_W   = 36;
    localparam int unsigned YEAR_W   = 13;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;

    localparam int unsigned SECONDS_BITS_DEF = 36;

    // 86400 = 128 * 675: the low seven bits go straight to the time of day.
    localparam int unsigned TOD_LOW_W  = 7;
    localparam int unsigned DIV_REM_W  = 10;
    localparam int unsigned DIV_STEP   = 4;
    localparam logic [DIV_REM_W:0] DAY_DIV = 11'd675;

    // Internal widths, sized for the largest day count a 36-bit word can give.
    localparam int unsigned DAYS_W  = 20;
    localparam int unsigned Z_W     = 20;
    localparam int unsigned ERA_W   = 3;
    localparam int unsigned DOE_W   = 18;
    localparam int unsigned TOD_W   = 17;
    localparam int unsigned TMIN_W  = 11;
    localparam int unsigned A_W     = 7;
    localparam int unsigned B_W     = 3;
    localparam int unsigned CENT_W  = 2;
    localparam int unsigned YOE_W   = 9;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned MP_W    = 4;
    localparam int unsigned YCALC_W = 14;

    // Days from 1600-03-01 to 1970-01-01.
    localparam logic [Z_W-1:0]     Z_OFFSET     = 20'd135080;
    localparam logic [Z_W-1:0]     DAYS_PER_ERA = 20'd146097;
    localparam logic [DOE_W-1:0]   DAYS_PER_CENT = 18'd36524;
    localparam logic [DOE_W-1:0]   LAST_DOE     = 18'd146096;
    localparam logic [DOE_W-1:0]   DAYS_PER_YEAR = 18'd365;
    localparam logic [TOD_W-1:0]   SECS_PER_MIN = 17'd60;
    localparam logic [TMIN_W-1:0]  MINS_PER_HOUR = 11'd60;
    localparam logic [YOE_W-1:0]   YEARS_PER_CENT = 9'd100;
    localparam logic [YCALC_W-1:0] YEARS_PER_ERA = 14'd400;
    localparam logic [YCALC_W-1:0] YEAR_BASE    = 14'd1600;
    localparam logic [YCALC_W-1:0] YEAR_LIMIT   = 14'd4147;
    localparam logic [MP_W-1:0]    MP_JAN       = 4'd10;
    localparam logic [MP_W-1:0]    MP_LAST      = 4'd11;

    // Rounded-up reciprocals; each is exact over the operand range it sees.
    localparam int unsigned ERA_SHIFT = 38;
    localparam int unsigned ERA_RCP_W = 21;
    localparam logic [ERA_RCP_W-1:0] ERA_RCP =
        ERA_RCP_W'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);

    localparam int unsigned R60_SHIFT = 28;
    localparam int unsigned R60_W     = 23;
    localparam logic [R60_W-1:0] R60_RCP =
        R60_W'(((64'd1 << R60_SHIFT) + 64'd59) / 64'd60);

    localparam int unsigned R1460_SHIFT = 29;
    localparam int unsigned R1460_W     = 19;
    localparam logic [R1460_W-1:0] R1460_RCP =
        R1460_W'(((64'd1 << R1460_SHIFT) + 64'd1459) / 64'd1460);

    localparam int unsigned R365_SHIFT = 27;
    localparam int unsigned R365_W     = 19;
    localparam logic [R365_W-1:0] R365_RCP =
        R365_W'(((64'd1 << R365_SHIFT) + 64'd364) / 64'd365);

    // First day of each month in a year that starts on the first of March.
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] res;
        unique case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/epoch_seconds_to_calendar.sv */
// Pipelined conversion of a UNIX time in seconds to Gregorian UTC date and time of day.
// The long division by 675 that yields the day count runs in the divider stages, four
// quotient bits per stage.
// Throughput: one word per cycle; a stall holds only the stages that are full behind it.
// Reset (rst_n, asynchronous, active low) empties every stage; data registers keep no reset.
module epoch_seconds_to_calendar #(
    parameter int unsigned SECONDS_BITS = estc_pkg::SECONDS_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sec_valid,
    output logic                           sec_stall,
    input  logic [estc_pkg::UNIX_W-1:0]    unix_seconds,
    output logic                           cal_valid,
    input  logic                           cal_stall,
    output logic [estc_pkg::YEAR_W-1:0]    year,
    output logic [estc_pkg::MONTH_W-1:0]   month,
    output logic [estc_pkg::DAY_W-1:0]     day,
    output logic [estc_pkg::HOUR_W-1:0]    hour,
    output logic [estc_pkg::MINUTE_W-1:0]  minute,
    output logic [estc_pkg::SECOND_W-1:0]  second,
    output logic                           out_of_range
);
    import estc_pkg::*;

    // Only bits of the word that exist and that the width setting keeps take part.
    localparam int unsigned EFF_BITS   = (SECONDS_BITS < UNIX_W) ? SECONDS_BITS : UNIX_W;
    localparam int unsigned QUO_BITS   = EFF_BITS - TOD_LOW_W;
    localparam int unsigned DIV_STAGES = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int unsigned NUM_W      = DIV_STAGES * DIV_STEP;
    localparam int unsigned N_STAGES   = DIV_STAGES + 9;

    // Stage positions after the divider.
    localparam int unsigned ST_Z   = DIV_STAGES;
    localparam int unsigned ST_ERA = DIV_STAGES + 1;
    localparam int unsigned ST_DOE = DIV_STAGES + 2;
    localparam int unsigned ST_ABC = DIV_STAGES + 3;
    localparam int unsigned ST_N   = DIV_STAGES + 4;
    localparam int unsigned ST_YOE = DIV_STAGES + 5;
    localparam int unsigned ST_DOY = DIV_STAGES + 6;
    localparam int unsigned ST_MP  = DIV_STAGES + 7;
    localparam int unsigned ST_OUT = DIV_STAGES + 8;

    localparam int unsigned ERA_PW   = Z_W + ERA_RCP_W;
    localparam int unsigned TODP_W   = TOD_W + R60_W;
    localparam int unsigned TMINP_W  = TMIN_W + R60_W;
    localparam int unsigned R1460P_W = DOE_W + R1460_W;
    localparam int unsigned R365P_W  = DOE_W + R365_W;

    // ------------------------------------------------------------------
    // Flow control. Each stage holds a valid bit; a stage takes a new word
    // whenever it is empty or the stage after it moves on, so bubbles
    // close up while the output is stalled.
    // ------------------------------------------------------------------
    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] vld_next;
    logic [N_STAGES-1:0] vld_in;
    logic [N_STAGES-1:0] rdy;

    always_comb
    begin
        rdy[N_STAGES-1] = !vld_reg[N_STAGES-1] || !cal_stall;
        for (int k = N_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in    = {vld_reg[N_STAGES-2:0], sec_valid};
    assign vld_next  = (rdy & vld_in) | (~rdy & vld_reg);
    assign sec_stall = !rdy[0];
    assign cal_valid = vld_reg[N_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Days and seconds of the day. The seconds above the low seven bits
    // are divided by 675 with a restoring long division, four quotient
    // bits per stage. The quotient is the day count; the remainder,
    // joined with the low seven bits, is the second of the day.
    // ------------------------------------------------------------------
    logic [DIV_REM_W-1:0] div_rem_reg [DIV_STAGES];
    logic [NUM_W-1:0]     div_num_reg [DIV_STAGES];
    logic [TOD_LOW_W-1:0] div_low_reg [DIV_STAGES];

    for (genvar gd = 0; gd < DIV_STAGES; gd++)
    begin : g_div
        logic [DIV_REM_W-1:0] rem_in;
        logic [DIV_REM_W-1:0] rem_next;
        logic [NUM_W-1:0]     num_in;
        logic [NUM_W-1:0]     num_next;
        logic [TOD_LOW_W-1:0] low_in;

        if (gd == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = NUM_W'(unix_seconds[EFF_BITS-1:TOD_LOW_W]);
            assign low_in = unix_seconds[TOD_LOW_W-1:0];
        end
        else
        begin : g_rest
            assign rem_in = div_rem_reg[gd-1];
            assign num_in = div_num_reg[gd-1];
            assign low_in = div_low_reg[gd-1];
        end

        always_comb
        begin : div_steps
            logic [DIV_REM_W:0] trial;
            rem_next = rem_in;
            num_next = num_in;
            for (int s = 0; s < DIV_STEP; s++)
            begin
                trial    = {rem_next, num_next[NUM_W-1]};
                num_next = {num_next[NUM_W-2:0], 1'b0};
                if (trial >= DAY_DIV)
                begin
                    rem_next    = DIV_REM_W'(trial - DAY_DIV);
                    num_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = trial[DIV_REM_W-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[gd])
            begin
                div_rem_reg[gd] <= rem_next;
                div_num_reg[gd] <= num_next;
                div_low_reg[gd] <= low_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Day count moved to a 400-year era that starts on 1600-03-01, so the
    // leap day falls at the end of each year and the year of the era,
    // the day of that year and the month follow by plain arithmetic.
    // ------------------------------------------------------------------
    logic [Z_W-1:0]   p1_z_reg;
    logic [Z_W-1:0]   p1_z_next;
    logic [TOD_W-1:0] p1_tod_reg;
    logic [TOD_W-1:0] p1_tod_next;

    assign p1_z_next   = Z_W'(div_num_reg[DIV_STAGES-1][DAYS_W-1:0]) + Z_OFFSET;
    assign p1_tod_next = {div_rem_reg[DIV_STAGES-1], div_low_reg[DIV_STAGES-1]};

    always_ff @(posedge clk)
    begin
        if (rdy[ST_Z])
        begin
            p1_z_reg   <= p1_z_next;
            p1_tod_reg <= p1_tod_next;
        end
    end

    // Era number and minute of the day, both by reciprocal multiplication.
    logic [ERA_PW-1:0] era_prod;
    logic [TODP_W-1:0] tmin_prod;
    logic [Z_W-1:0]    p2_z_reg;
    logic [ERA_W-1:0]  p2_era_reg;
    logic [ERA_W-1:0]  p2_era_next;
    logic [TOD_W-1:0]  p2_tod_reg;
    logic [TMIN_W-1:0] p2_tmin_reg;
    logic [TMIN_W-1:0] p2_tmin_next;

    assign era_prod     = ERA_PW'(p1_z_reg) * ERA_PW'(ERA_RCP);
    assign p2_era_next  = ERA_W'(era_prod >> ERA_SHIFT);
    assign tmin_prod    = TODP_W'(p1_tod_reg) * TODP_W'(R60_RCP);
    assign p2_tmin_next = TMIN_W'(tmin_prod >> R60_SHIFT);

    always_ff @(posedge clk)
    begin
        if (rdy[ST_ERA])
        begin
            p2_z_reg    <= p1_z_reg;
            p2_era_reg  <= p2_era_next;
            p2_tod_reg  <= p1_tod_reg;
            p2_tmin_reg <= p2_tmin_next;
        end
    end

    // Day of the era and second of the minute.
    logic [DOE_W-1:0]    p3_doe_reg;
    logic [DOE_W-1:0]    p3_doe_next;
    logic [ERA_W-1:0]    p3_era_reg;
    logic [TMIN_W-1:0]   p3_tmin_reg;
    logic [SECOND_W-1:0] p3_sec_reg;
    logic [SECOND_W-1:0] p3_sec_next;

    assign p3_doe_next = DOE_W'(p2_z_reg - Z_W'(Z_W'(p2_era_reg) * DAYS_PER_ERA));
    assign p3_sec_next = SECOND_W'(p2_tod_reg - TOD_W'(TOD_W'(p2_tmin_reg) * SECS_PER_MIN));

    always_ff @(posedge clk)
    begin
        if (rdy[ST_DOE])
        begin
            p3_doe_reg  <= p3_doe_next;
            p3_era_reg  <= p2_era_reg;
            p3_tmin_reg <= p2_tmin_reg;
            p3_sec_reg  <= p3_sec_next;
        end
    end

    // Leap-day corrections: four-year groups, centuries and the final day
    // of the era; hour of the day alongside.
    logic [R1460P_W-1:0] a_prod;
    logic [TMINP_W-1:0]  hr_prod;
    logic [DOE_W-1:0]    p4_doe_reg;
    logic [A_W-1:0]      p4_a_reg;
    logic [A_W-1:0]      p4_a_next;
    logic [B_W-1:0]      p4_b_reg;
    logic [B_W-1:0]      p4_b_next;
    logic                p4_c_reg;
    logic                p4_c_next;
    logic [ERA_W-1:0]    p4_era_reg;
    logic [TMIN_W-1:0]   p4_tmin_reg;
    logic [HOUR_W-1:0]   p4_hr_reg;
    logic [HOUR_W-1:0]   p4_hr_next;
    logic [SECOND_W-1:0] p4_sec_reg;

    assign a_prod     = R1460P_W'(p3_doe_reg) * R1460P_W'(R1460_RCP);
    assign p4_a_next  = A_W'(a_prod >> R1460_SHIFT);
    assign p4_b_next  = B_W'(p3_doe_reg >= DAYS_PER_CENT)
                      + B_W'(p3_doe_reg >= DOE_W'(2 * DAYS_PER_CENT))
                      + B_W'(p3_doe_reg >= DOE_W'(3 * DAYS_PER_CENT))
                      + B_W'(p3_doe_reg >= DOE_W'(4 * DAYS_PER_CENT));
    assign p4_c_next  = (p3_doe_reg == LAST_DOE);
    assign hr_prod    = TMINP_W'(p3_tmin_reg) * TMINP_W'(R60_RCP);
    assign p4_hr_next = HOUR_W'(hr_prod >> R60_SHIFT);

    always_ff @(posedge clk)
    begin
        if (rdy[ST_ABC])
        begin
            p4_doe_reg  <= p3_doe_reg;
            p4_a_reg    <= p4_a_next;
            p4_b_reg    <= p4_b_next;
            p4_c_reg    <= p4_c_next;
            p4_era_reg  <= p3_era_reg;
            p4_tmin_reg <= p3_tmin_reg;
            p4_hr_reg   <= p4_hr_next;
            p4_sec_reg  <= p3_sec_reg;
        end
    end

    // Day of the era with leap days taken out, ready to split into years;
    // minute of the hour alongside.
    logic [DOE_W-1:0]    p5_n_reg;
    logic [DOE_W-1:0]    p5_n_next;
    logic [DOE_W-1:0]    p5_doe_reg;
    logic [ERA_W-1:0]    p5_era_reg;
    logic [HOUR_W-1:0]   p5_hr_reg;
    logic [MINUTE_W-1:0] p5_min_reg;
    logic [MINUTE_W-1:0] p5_min_next;
    logic [SECOND_W-1:0] p5_sec_reg;

    assign p5_n_next   = p4_doe_reg - DOE_W'(p4_a_reg) + DOE_W'(p4_b_reg) - DOE_W'(p4_c_reg);
    assign p5_min_next = MINUTE_W'(p4_tmin_reg
                       - TMIN_W'(TMIN_W'(p4_hr_reg) * MINS_PER_HOUR));

    always_ff @(posedge clk)
    begin
        if (rdy[ST_N])
        begin
            p5_n_reg   <= p5_n_next;
            p5_doe_reg <= p4_doe_reg;
            p5_era_reg <= p4_era_reg;
            p5_hr_reg  <= p4_hr_reg;
            p5_min_reg <= p5_min_next;
            p5_sec_reg <= p4_sec_reg;
        end
    end

    // Year of the era.
    logic [R365P_W-1:0]  yoe_prod;
    logic [YOE_W-1:0]    p6_yoe_reg;
    logic [YOE_W-1:0]    p6_yoe_next;
    logic [DOE_W-1:0]    p6_doe_reg;
    logic [ERA_W-1:0]    p6_era_reg;
    logic [HOUR_W-1:0]   p6_hr_reg;
    logic [MINUTE_W-1:0] p6_min_reg;
    logic [SECOND_W-1:0] p6_sec_reg;

    assign yoe_prod    = R365P_W'(p5_n_reg) * R365P_W'(R365_RCP);
    assign p6_yoe_next = YOE_W'(yoe_prod >> R365_SHIFT);

    always_ff @(posedge clk)
    begin
        if (rdy[ST_YOE])
        begin
            p6_yoe_reg <= p6_yoe_next;
            p6_doe_reg <= p5_doe_reg;
            p6_era_reg <= p5_era_reg;
            p6_hr_reg  <= p5_hr_reg;
            p6_min_reg <= p5_min_reg;
            p6_sec_reg <= p5_sec_reg;
        end
    end

    // Day of the March-based year.
    logic [CENT_W-1:0]   cent;
    logic [DOE_W-1:0]    year_start;
    logic [DOY_W-1:0]    p7_doy_reg;
    logic [DOY_W-1:0]    p7_doy_next;
    logic [YOE_W-1:0]    p7_yoe_reg;
    logic [ERA_W-1:0]    p7_era_reg;
    logic [HOUR_W-1:0]   p7_hr_reg;
    logic [MINUTE_W-1:0] p7_min_reg;
    logic [SECOND_W-1:0] p7_sec_reg;

    assign cent        = CENT_W'(p6_yoe_reg >= YEARS_PER_CENT)
                       + CENT_W'(p6_yoe_reg >= YOE_W'(2 * YEARS_PER_CENT))
                       + CENT_W'(p6_yoe_reg >= YOE_W'(3 * YEARS_PER_CENT));
    assign year_start  = DOE_W'(DOE_W'(p6_yoe_reg) * DAYS_PER_YEAR)
                       + DOE_W'(p6_yoe_reg >> 2) - DOE_W'(cent);
    assign p7_doy_next = DOY_W'(p6_doe_reg - year_start);

    always_ff @(posedge clk)
    begin
        if (rdy[ST_DOY])
        begin
            p7_doy_reg <= p7_doy_next;
            p7_yoe_reg <= p6_yoe_reg;
            p7_era_reg <= p6_era_reg;
            p7_hr_reg  <= p6_hr_reg;
            p7_min_reg <= p6_min_reg;
            p7_sec_reg <= p6_sec_reg;
        end
    end

    // Month of the March-based year: count the month starts already passed.
    logic [MP_W-1:0]     p8_mp_reg;
    logic [MP_W-1:0]     p8_mp_next;
    logic [DOY_W-1:0]    p8_doy_reg;
    logic [YOE_W-1:0]    p8_yoe_reg;
    logic [ERA_W-1:0]    p8_era_reg;
    logic [HOUR_W-1:0]   p8_hr_reg;
    logic [MINUTE_W-1:0] p8_min_reg;
    logic [SECOND_W-1:0] p8_sec_reg;

    always_comb
    begin
        p8_mp_next = '0;
        for (int i = 1; i <= int'(MP_LAST); i++)
        begin
            p8_mp_next = p8_mp_next + MP_W'(p7_doy_reg >= month_start(MP_W'(i)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_MP])
        begin
            p8_mp_reg  <= p8_mp_next;
            p8_doy_reg <= p7_doy_reg;
            p8_yoe_reg <= p7_yoe_reg;
            p8_era_reg <= p7_era_reg;
            p8_hr_reg  <= p7_hr_reg;
            p8_min_reg <= p7_min_reg;
            p8_sec_reg <= p7_sec_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register. January and February belong to the following
    // civil year. A year beyond the supported range gives all-zero fields
    // with the range flag set.
    // ------------------------------------------------------------------
    logic                jan_feb;
    logic [YCALC_W-1:0]  year_calc;
    logic                oor;
    logic [MONTH_W-1:0]  month_calc;
    logic [DAY_W-1:0]    day_calc;

    logic [YEAR_W-1:0]   year_reg;
    logic [YEAR_W-1:0]   year_next;
    logic [MONTH_W-1:0]  month_reg;
    logic [MONTH_W-1:0]  month_next;
    logic [DAY_W-1:0]    day_reg;
    logic [DAY_W-1:0]    day_next;
    logic [HOUR_W-1:0]   hour_reg;
    logic [HOUR_W-1:0]   hour_next;
    logic [MINUTE_W-1:0] minute_reg;
    logic [MINUTE_W-1:0] minute_next;
    logic [SECOND_W-1:0] second_reg;
    logic [SECOND_W-1:0] second_next;
    logic                oor_reg;

    assign jan_feb    = (p8_mp_reg >= MP_JAN);
    assign month_calc = jan_feb ? MONTH_W'(p8_mp_reg - MP_W'(9)) : MONTH_W'(p8_mp_reg + MP_W'(3));
    assign day_calc   = DAY_W'(p8_doy_reg - month_start(p8_mp_reg) + DOY_W'(1));
    assign year_calc  = YEAR_BASE + YCALC_W'(p8_era_reg) * YEARS_PER_ERA
                      + YCALC_W'(p8_yoe_reg) + YCALC_W'(jan_feb);
    assign oor        = (year_calc > YEAR_LIMIT);

    assign year_next   = oor ? '0 : YEAR_W'(year_calc);
    assign month_next  = oor ? '0 : month_calc;
    assign day_next    = oor ? '0 : day_calc;
    assign hour_next   = oor ? '0 : p8_hr_reg;
    assign minute_next = oor ? '0 : p8_min_reg;
    assign second_next = oor ? '0 : p8_sec_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            oor_reg    <= oor;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day          = day_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign out_of_range = oor_reg;

endmodule

/* test/tb.sv */
// Self-checking testbench for the epoch-seconds to calendar-date converter.

typedef struct packed {
    logic [estc_pkg::YEAR_W-1:0]   year;
    logic [estc_pkg::MONTH_W-1:0]  month;
    logic [estc_pkg::DAY_W-1:0]    day;
    logic [estc_pkg::HOUR_W-1:0]   hour;
    logic [estc_pkg::MINUTE_W-1:0] minute;
    logic [estc_pkg::SECOND_W-1:0] second;
    logic                          out_of_range;
} cal_word_t;

localparam int unsigned TB_SEC_BITS     = estc_pkg::SECONDS_BITS_DEF;
localparam longint unsigned DAY_SECS    = 86400;
localparam longint unsigned HOUR_SECS   = 3600;
localparam longint unsigned MIN_SECS    = 60;
localparam longint unsigned ERA_DAYS    = 146097;
localparam longint unsigned ERA_TO_1970 = 135140;
localparam longint unsigned ERA_YEAR    = 1600;
localparam longint unsigned FIRST_YEAR  = 1970;
localparam longint unsigned LAST_YEAR   = 4147;
localparam int unsigned MONTH_LEN [12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

function automatic longint unsigned leap_extra_day(longint unsigned y);
    if (y % 400 == 0) return 1;
    if (y % 100 == 0) return 0;
    return (y % 4 == 0) ? 1 : 0;
endfunction

function automatic longint unsigned days_in_month(longint unsigned y, int unsigned m);
    return MONTH_LEN[m] + ((m == 1) ? leap_extra_day(y) : 0);
endfunction

// Expected calendar word for one timestamp.
function automatic cal_word_t civil_from_epoch(logic [estc_pkg::UNIX_W-1:0] stamp);
    longint unsigned secs, days, tod, z, yr, rem, ylen;
    int unsigned mon;
    cal_word_t w;
    secs = longint'(stamp) & ((64'd1 << TB_SEC_BITS) - 1);
    days = secs / DAY_SECS;
    tod  = secs % DAY_SECS;
    z    = days + ERA_TO_1970;
    yr   = ERA_YEAR + 400 * (z / ERA_DAYS);
    rem  = z % ERA_DAYS;
    forever begin
        ylen = 365 + leap_extra_day(yr);
        if (rem < ylen) break;
        rem -= ylen;
        yr++;
    end
    mon = 0;
    while (mon < 11 && rem >= days_in_month(yr, mon)) begin
        rem -= days_in_month(yr, mon);
        mon++;
    end
    w = '0;
    if (yr > LAST_YEAR || yr < FIRST_YEAR) begin
        w.out_of_range = 1'b1;
    end
    else begin
        w.year   = yr[estc_pkg::YEAR_W-1:0];
        w.month  = estc_pkg::MONTH_W'(mon + 1);
        w.day    = estc_pkg::DAY_W'(rem + 1);
        w.hour   = estc_pkg::HOUR_W'(tod / HOUR_SECS);
        w.minute = estc_pkg::MINUTE_W'((tod % HOUR_SECS) / MIN_SECS);
        w.second = estc_pkg::SECOND_W'(tod % MIN_SECS);
    end
    return w;
endfunction

class calendar_scoreboard;
    cal_word_t   dates_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned leap_days;
    int unsigned year_ends;

    task report_mismatch(string msg);
        $display("mismatch %0d: %s", mismatches + 1, msg);
        mismatches++;
    endtask

    function void note_input(logic [estc_pkg::UNIX_W-1:0] stamp);
        dates_due.push_back(civil_from_epoch(stamp));
    endfunction

    task check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            report_mismatch($sformatf("word %0d field %s: expected %0d, got %0d",
                                      checked, name, want, got));
    endtask

    task check_result(cal_word_t got);
        cal_word_t want;
        if (dates_due.size() == 0) begin
            report_mismatch("calendar word with no timestamp waiting");
            return;
        end
        want = dates_due.pop_front();
        check_field("year", 16'(want.year), 16'(got.year));
        check_field("month", 16'(want.month), 16'(got.month));
        check_field("day", 16'(want.day), 16'(got.day));
        check_field("hour", 16'(want.hour), 16'(got.hour));
        check_field("minute", 16'(want.minute), 16'(got.minute));
        check_field("second", 16'(want.second), 16'(got.second));
        check_field("out_of_range", 16'(want.out_of_range), 16'(got.out_of_range));
        if (want.month == 2 && want.day == 29) leap_days++;
        if (want.month == 12 && want.day == 31) year_ends++;
        checked++;
    endtask
endclass

module tb;

    localparam int unsigned RANDOM_WORDS = 1700;
    localparam int unsigned PHASE_WORDS  = 200;
    localparam int unsigned HOLD_CYCLES  = 300;
    // Comfortably longer than the pipeline latency.
    localparam int unsigned DRAIN_CYCLES = 64;
    // Largest day number whose whole day still fits in a 36-bit count of seconds.
    localparam int unsigned LAST_FULL_DAY = 795363;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           sec_valid = 1'b0;
    logic                           sec_stall;
    logic [estc_pkg::UNIX_W-1:0]    unix_seconds = '0;
    logic                           cal_valid;
    logic                           cal_stall = 1'b0;
    logic [estc_pkg::YEAR_W-1:0]    year;
    logic [estc_pkg::MONTH_W-1:0]   month;
    logic [estc_pkg::DAY_W-1:0]     day;
    logic [estc_pkg::HOUR_W-1:0]    hour;
    logic [estc_pkg::MINUTE_W-1:0]  minute;
    logic [estc_pkg::SECOND_W-1:0]  second;
    logic                           out_of_range;

    calendar_scoreboard sb = new;

    // Flags shared between the stimulus and the receiving process, and the back-pressure count.
    bit          no_idle = 1'b0;
    bit          long_hold = 1'b0;
    int unsigned back_pressure = 0;

    // Timestamps that sit on the edges the conversion must get right: the epoch, the top
    // of the input range, alternating bit patterns, the 32-bit wrap, the ends of days and
    // months, the leap day of a leap year, the last day of a leap year, and the skipped
    // leap day of a century year that is not divisible by 400.
    logic [estc_pkg::UNIX_W-1:0] directed_words [$] = '{
        36'd0, 36'hFFFFFFFFF, 36'hAAAAAAAAA, 36'h555555555, 36'hFFFFFFFF, 36'h100000000,
        36'd86399, 36'd86400, 36'd2678399, 36'd2678400, 36'd5097599, 36'd5097600,
        36'd68169600, 36'd68255999, 36'd68256000, 36'd94694399, 36'd94694400,
        36'd951782400, 36'd978307199, 36'd978307200, 36'd4107542399, 36'd4107542400,
        36'd4133980799
    };

    epoch_seconds_to_calendar u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sec_valid    (sec_valid),
        .sec_stall    (sec_stall),
        .unix_seconds (unix_seconds),
        .cal_valid    (cal_valid),
        .cal_stall    (cal_stall),
        .year         (year),
        .month        (month),
        .day          (day),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .out_of_range (out_of_range)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run, even with every gap, every stall and both
    // long hold-offs at their worst.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Draws a timestamp. Four in ten are spread over the whole range; most others are aimed at
    // the edges of days, months and years, where a slip of one in the day count would show.
    function automatic logic [estc_pkg::UNIX_W-1:0] random_stamp();
        longint unsigned days, secs, yr;
        int unsigned mon, k, kind;
        kind = $urandom_range(0, 9);
        secs = 0;
        if (kind <= 3) begin
            secs = {$urandom, $urandom};
        end
        else if (kind <= 5) begin
            days = $urandom_range(0, LAST_FULL_DAY);
            case ($urandom_range(0, 2))
                0:       secs = days * DAY_SECS;
                1:       secs = days * DAY_SECS + DAY_SECS - 1;
                default: secs = days * DAY_SECS + $urandom_range(0, DAY_SECS - 1);
            endcase
        end
        else if (kind <= 8) begin
            // First or last second of a random month in a random year.
            yr   = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
            mon  = $urandom_range(0, 11);
            days = 365 * (yr - FIRST_YEAR)
                 + ((yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400)
                 - ((FIRST_YEAR - 1) / 4 - (FIRST_YEAR - 1) / 100 + (FIRST_YEAR - 1) / 400);
            for (k = 0; k < mon; k++) days += days_in_month(yr, k);
            if ($urandom_range(0, 1) == 0)
                secs = days * DAY_SECS;
            else
                secs = (days + days_in_month(yr, mon)) * DAY_SECS - 1;
        end
        else begin
            // Either very small counts or the last few days of the range.
            if ($urandom_range(0, 1) == 0)
                secs = $urandom_range(0, 1 << 20);
            else
                secs = 64'hF_FFFF_FFFF - $urandom_range(0, 400000);
        end
        return secs[estc_pkg::UNIX_W-1:0];
    endfunction

    // Offers one timestamp and waits until the block takes it. The valid is left high
    // after acceptance, so that back-to-back words keep it high without a glitch.
    task automatic offer_word(input logic [estc_pkg::UNIX_W-1:0] stamp);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            sec_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sec_valid    <= 1'b1;
        unix_seconds <= stamp;
        do
        begin
            @(posedge clk);
            if (sec_stall) back_pressure++;
        end
        while (sec_stall);
        sb.note_input(stamp);
    endtask

    // Receiving side: a random stall before each word, or now and then a long hold-off so
    // that the pipeline fills and pushes back on the sender.
    initial
    begin
        int unsigned gap;
        @(posedge rst_n);
        forever
        begin
            if (long_hold) begin
                cal_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                cal_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            cal_stall <= 1'b0;
            do @(posedge clk); while (!cal_valid);
        end
    end

    // Every word that leaves the block is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && cal_valid && !cal_stall)
            sb.check_result('{year, month, day, hour, minute, second, out_of_range});
    end

    initial
    begin
        int unsigned n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i]) offer_word(directed_words[i]);

        // Alternate blocks with random idling on both sides and blocks with none at all;
        // two long hold-offs of the receiver land inside blocks where the sender never
        // pauses, so the input side is certain to see back-pressure.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_WORDS == 0) no_idle = ((n / PHASE_WORDS) % 2) == 1;
            if (n == PHASE_WORDS + 50 || n == 5 * PHASE_WORDS + 50) long_hold = 1'b1;
            offer_word(random_stamp());
        end
        sec_valid <= 1'b0;

        while (sb.dates_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.dates_due.size() != 0)
            sb.report_mismatch($sformatf("%0d calendar words never arrived",
                                         sb.dates_due.size()));

        $display("converted %0d timestamps, %0d on a leap day and %0d on the last day of a year",
                 sb.checked, sb.leap_days, sb.year_ends);
        $display("input held back on %0d cycles while the output was stalled", back_pressure);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
